// ----- sv/keypad_code_lock_controller_top_assert.svh -----
// Assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define KCLC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kclc: same-cycle check failed");

// Next-cycle implication.
`define KCLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kclc: next-cycle check failed");

`endif

// ----- sv/kclc_pkg.sv -----
package kclc_pkg;

    localparam int CODE_LENGTH = 10;

    localparam int IDX_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int CNT_W   = $clog2(CODE_LENGTH + 1);
    // position in a result list: up to four plain results, or a code dump
    localparam int POS_MAX = (CODE_LENGTH + 2 > 5) ? (CODE_LENGTH + 2) : 5;
    localparam int POS_W   = $clog2(POS_MAX);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_ENTRY,
        MODE_MENU,
        MODE_NEWCODE
    } mode_t;

    localparam logic [2:0] EV_STAR   = 3'd0;
    localparam logic [2:0] EV_CLEAR  = 3'd1;
    localparam logic [2:0] EV_MENU   = 3'd2;
    localparam logic [2:0] EV_RETRY  = 3'd3;
    localparam logic [2:0] EV_FAILED = 3'd4;
    localparam logic [2:0] EV_PROMPT = 3'd5;

    localparam logic KIND_LINK  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENTER_CODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIGIT_LIMIT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRONG_LIMIT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_BYTE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_BYTE     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANGE_BYTE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_CHOICE   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANGE_CHOICE = 3'd7;

    localparam logic [7:0] RST_ENTER_CODE    = 8'd16;
    localparam logic [7:0] RST_DIGIT_LIMIT   = 8'd8;
    localparam logic [1:0] RST_WRONG_LIMIT   = 2'd3;
    localparam logic [7:0] RST_ALARM_BYTE    = 8'd10;
    localparam logic [7:0] RST_OPEN_BYTE     = 8'd11;
    localparam logic [7:0] RST_CHANGE_BYTE   = 8'd12;
    localparam logic [7:0] RST_OPEN_CHOICE   = 8'd1;
    localparam logic [7:0] RST_CHANGE_CHOICE = 8'd2;

    typedef logic [CODE_LENGTH-1:0][7:0] code_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] link_byte;
        logic [2:0] display_event;
    } result_t;

endpackage

// ----- sv/keypad_code_lock_controller_top.sv -----
// Channel  Dir  tdata (low bit up)                      tuser    tlast
// s_axis   in   value[7:0]                              command  -
// m_axis   out  link_byte[7:0], display_event[10:8]     kind     last
// cfg      in   write enable, register index, data      -        -
//
// An item is held in the input register, then decoded into a result list that
// the output register sends one result per cycle while m_axis is ready. Every
// item waits in the input register until the previous item's list has drained;
// a list holds at most CODE_LENGTH + 2 results.
// Reset is synchronous on aresetn low; code stores clear at once, no sweep.
// A stalled m_axis holds its result; s_axis keeps one item buffered meanwhile.
module keypad_code_lock_controller_top
    import kclc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // value[7:0]
    input  logic                  s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // link_byte[7:0], display_event[10:8]
    output logic                  m_axis_tuser,   // kind
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [7:0] enter_code_reg;
    logic [7:0] digit_limit_reg;
    logic [1:0] wrong_limit_reg;
    logic [7:0] alarm_byte_reg;
    logic [7:0] open_byte_reg;
    logic [7:0] change_byte_reg;
    logic [7:0] open_choice_reg;
    logic [7:0] change_choice_reg;

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_value_reg;

    // lock state
    mode_t             mode_reg, mode_next;
    code_t             ref_reg, ref_next;
    code_t             buffer_reg, buffer_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [IDX_W-1:0]  load_index_reg, load_index_next;
    logic [1:0]        wrong_count_reg, wrong_count_next;
    logic              prompt_cleared_reg, prompt_cleared_next;

    // result list
    logic               plan_valid_reg;
    result_t [3:0]      plan_ent_reg, plan_ent_next;
    logic [2:0]         plan_cnt_reg, plan_cnt_next;
    logic               plan_dump_reg, plan_dump_next;
    code_t              plan_snap_reg;
    logic [POS_W-1:0]   pos_reg;

    logic       key_in, link_in;
    logic       is_enter, is_digit, code_match, final_try, has_room;
    logic [1:0] limit_eff;
    logic       proc, has_results, m_fire, plan_done;
    result_t    out_res;
    logic       out_last;

    function automatic result_t ev_res(logic [2:0] ev);
        result_t r;
        r.kind          = KIND_EVENT;
        r.link_byte     = 8'd0;
        r.display_event = ev;
        return r;
    endfunction

    function automatic result_t link_res(logic [7:0] b);
        result_t r;
        r.kind          = KIND_LINK;
        r.link_byte     = b;
        r.display_event = 3'd0;
        return r;
    endfunction

    // ---------------- handshake ----------------
    assign m_fire    = plan_valid_reg && m_axis_tready;
    assign plan_done = m_fire && out_last;
    assign proc      = in_valid_reg && (!plan_valid_reg || plan_done);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg   <= s_axis_tuser;
            in_value_reg <= s_axis_tdata;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_code_reg    <= RST_ENTER_CODE;
            digit_limit_reg   <= RST_DIGIT_LIMIT;
            wrong_limit_reg   <= RST_WRONG_LIMIT;
            alarm_byte_reg    <= RST_ALARM_BYTE;
            open_byte_reg     <= RST_OPEN_BYTE;
            change_byte_reg   <= RST_CHANGE_BYTE;
            open_choice_reg   <= RST_OPEN_CHOICE;
            change_choice_reg <= RST_CHANGE_CHOICE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ENTER_CODE:    enter_code_reg    <= cfg_wdata;
                CFG_DIGIT_LIMIT:   digit_limit_reg   <= cfg_wdata;
                CFG_WRONG_LIMIT:   wrong_limit_reg   <= cfg_wdata[1:0];
                CFG_ALARM_BYTE:    alarm_byte_reg    <= cfg_wdata;
                CFG_OPEN_BYTE:     open_byte_reg     <= cfg_wdata;
                CFG_CHANGE_BYTE:   change_byte_reg   <= cfg_wdata;
                CFG_OPEN_CHOICE:   open_choice_reg   <= cfg_wdata;
                CFG_CHANGE_CHOICE: change_choice_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- decode ----------------
    always_comb begin
        key_in     = !in_cmd_reg;
        link_in    = in_cmd_reg;
        is_enter   = in_value_reg == enter_code_reg;
        is_digit   = (in_value_reg != 8'd0) && !is_enter && (in_value_reg <= digit_limit_reg);
        code_match = buffer_reg == ref_reg;
        // a limit of zero behaves as one
        limit_eff  = (wrong_limit_reg == 2'd0) ? 2'd1 : wrong_limit_reg;
        final_try  = ({1'b0, wrong_count_reg} + 3'd1) >= {1'b0, limit_eff};
        has_room   = entry_count_reg < CNT_W'(CODE_LENGTH);
    end

    // ---------------- next mode ----------------
    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_LOAD: begin
                if (link_in && load_index_reg == IDX_W'(CODE_LENGTH - 1))
                    mode_next = MODE_ENTRY;
            end
            MODE_ENTRY: begin
                if (key_in && is_enter && code_match)
                    mode_next = MODE_MENU;
            end
            MODE_MENU: begin
                if (key_in) begin
                    if (in_value_reg == open_choice_reg)
                        mode_next = MODE_ENTRY;
                    else if (in_value_reg == change_choice_reg)
                        mode_next = MODE_NEWCODE;
                end
            end
            MODE_NEWCODE: begin
                if (key_in && is_enter)
                    mode_next = MODE_LOAD;
            end
            default: mode_next = MODE_LOAD;
        endcase
    end

    // ---------------- data path and result list ----------------
    always_comb begin
        ref_next            = ref_reg;
        buffer_next         = buffer_reg;
        entry_count_next    = entry_count_reg;
        load_index_next     = load_index_reg;
        wrong_count_next    = wrong_count_reg;
        prompt_cleared_next = prompt_cleared_reg;
        plan_ent_next       = '0;
        plan_cnt_next       = 3'd0;
        plan_dump_next      = 1'b0;

        case (mode_reg)
            MODE_LOAD: begin
                if (link_in) begin
                    ref_next[load_index_reg] = in_value_reg;
                    if (load_index_reg == IDX_W'(CODE_LENGTH - 1))
                        load_index_next = '0;
                    else
                        load_index_next = load_index_reg + IDX_W'(1);
                end
            end
            MODE_ENTRY: begin
                if (key_in && is_enter) begin
                    buffer_next      = '0;
                    entry_count_next = '0;
                    plan_ent_next[0] = ev_res(EV_CLEAR);
                    if (code_match) begin
                        plan_ent_next[1] = ev_res(EV_MENU);
                        plan_cnt_next    = 3'd2;
                    end else if (final_try) begin
                        wrong_count_next    = 2'd0;
                        prompt_cleared_next = 1'b0;
                        plan_ent_next[1]    = ev_res(EV_FAILED);
                        plan_ent_next[2]    = link_res(alarm_byte_reg);
                        plan_ent_next[3]    = ev_res(EV_PROMPT);
                        plan_cnt_next       = 3'd4;
                    end else begin
                        wrong_count_next = wrong_count_reg + 2'd1;
                        plan_ent_next[1] = ev_res(EV_RETRY);
                        plan_ent_next[2] = ev_res(EV_CLEAR);
                        plan_cnt_next    = 3'd3;
                    end
                end else if (key_in && is_digit) begin
                    // first digit after a prompt wipes the display
                    if (!prompt_cleared_reg) begin
                        prompt_cleared_next = 1'b1;
                        plan_ent_next[0]    = ev_res(EV_CLEAR);
                        plan_cnt_next       = 3'd1;
                    end
                    if (has_room) begin
                        buffer_next[entry_count_reg[IDX_W-1:0]] = in_value_reg;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                        plan_ent_next[plan_cnt_next[1:0]] = ev_res(EV_STAR);
                        plan_cnt_next = plan_cnt_next + 3'd1;
                    end
                end
            end
            MODE_MENU: begin
                if (key_in) begin
                    if (in_value_reg == open_choice_reg) begin
                        prompt_cleared_next = 1'b0;
                        plan_ent_next[0]    = link_res(open_byte_reg);
                        plan_ent_next[1]    = ev_res(EV_PROMPT);
                        plan_cnt_next       = 3'd2;
                    end else if (in_value_reg == change_choice_reg) begin
                        plan_ent_next[0] = link_res(change_byte_reg);
                        plan_ent_next[1] = ev_res(EV_CLEAR);
                        plan_cnt_next    = 3'd2;
                    end
                end
            end
            MODE_NEWCODE: begin
                if (key_in && is_enter) begin
                    // marker, every buffer entry, then prompt
                    plan_ent_next[0]    = link_res(change_byte_reg);
                    plan_ent_next[1]    = ev_res(EV_PROMPT);
                    plan_cnt_next       = 3'd2;
                    plan_dump_next      = 1'b1;
                    buffer_next         = '0;
                    entry_count_next    = '0;
                    prompt_cleared_next = 1'b0;
                    ref_next            = '0;
                    load_index_next     = '0;
                end else if (key_in && is_digit && has_room) begin
                    buffer_next[entry_count_reg[IDX_W-1:0]] = in_value_reg;
                    entry_count_next = entry_count_reg + CNT_W'(1);
                    plan_ent_next[0] = ev_res(EV_STAR);
                    plan_cnt_next    = 3'd1;
                end
            end
            default: ;
        endcase

        has_results = (plan_cnt_next != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_LOAD;
            ref_reg            <= '0;
            buffer_reg         <= '0;
            entry_count_reg    <= '0;
            load_index_reg     <= '0;
            wrong_count_reg    <= 2'd0;
            prompt_cleared_reg <= 1'b0;
        end else if (proc) begin
            mode_reg           <= mode_next;
            ref_reg            <= ref_next;
            buffer_reg         <= buffer_next;
            entry_count_reg    <= entry_count_next;
            load_index_reg     <= load_index_next;
            wrong_count_reg    <= wrong_count_next;
            prompt_cleared_reg <= prompt_cleared_next;
        end
    end

    // ---------------- result sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end else if (proc && has_results) begin
            plan_valid_reg <= 1'b1;
            pos_reg        <= '0;
        end else if (m_fire) begin
            if (out_last) begin
                plan_valid_reg <= 1'b0;
                pos_reg        <= '0;
            end else begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end

        if (proc && has_results) begin
            plan_ent_reg  <= plan_ent_next;
            plan_cnt_reg  <= plan_cnt_next;
            plan_dump_reg <= plan_dump_next;
            plan_snap_reg <= buffer_reg;
        end else if (m_fire && pos_reg != '0) begin
            // dump bytes leave from the low end
            plan_snap_reg <= code_t'(plan_snap_reg >> 8);
        end
    end

    always_comb begin
        if (plan_dump_reg) begin
            out_last = pos_reg == POS_W'(CODE_LENGTH + 1);
            if (pos_reg == '0)
                out_res = plan_ent_reg[0];
            else if (out_last)
                out_res = plan_ent_reg[1];
            else
                out_res = link_res(plan_snap_reg[0]);
        end else begin
            out_last = POS_W'(plan_cnt_reg) == (pos_reg + POS_W'(1));
            out_res  = plan_ent_reg[pos_reg[1:0]];
        end
    end

    assign m_axis_tvalid = plan_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res.display_event, out_res.link_byte};
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tlast  = out_last;

    // ---------------- checks ----------------
`include "keypad_code_lock_controller_top_assert.svh"

    `KCLC_ASSERT_NOW(a_dump_pos, plan_valid_reg && plan_dump_reg, pos_reg <= POS_W'(CODE_LENGTH + 1))
    `KCLC_ASSERT_NOW(a_list_pos, plan_valid_reg && !plan_dump_reg, pos_reg < POS_W'(plan_cnt_reg))
    `KCLC_ASSERT_NEXT(a_pos_rewind, m_fire && out_last, pos_reg == '0)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import kclc_pkg::*;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_LINK = 1'b1;

    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 30;
    localparam int DRAIN_CYCLES     = 2 * (CODE_LENGTH + 2) + 4;
    localparam int MAX_SHOWN_ERRORS = 10;

    typedef struct {
        logic       cmd;
        logic [7:0] value;
    } lock_item_t;

    typedef struct {
        logic       kind;
        logic [7:0] link_byte;
        logic [2:0] display_event;
        logic       last;
    } lock_result_t;

    // directed opening: load a short code, a failed try, a login, a code change
    localparam logic [8:0] DIRECTED [24] = '{
        {CMD_KEY, 8'd255},              // keypress while loading is dropped
        {CMD_LINK, 8'd8}, {CMD_LINK, 8'd1}, {CMD_LINK, 8'd3},
        {CMD_LINK, 8'd0}, {CMD_LINK, 8'd0}, {CMD_LINK, 8'd0}, {CMD_LINK, 8'd0},
        {CMD_LINK, 8'd0}, {CMD_LINK, 8'd0}, {CMD_LINK, 8'd0},
        {CMD_LINK, 8'd255},             // link byte outside loading is dropped
        {CMD_KEY, 8'd0}, {CMD_KEY, RST_DIGIT_LIMIT + 8'd1},
        {CMD_KEY, 8'd8}, {CMD_KEY, RST_ENTER_CODE},
        {CMD_KEY, 8'd8}, {CMD_KEY, 8'd1}, {CMD_KEY, 8'd3}, {CMD_KEY, RST_ENTER_CODE},
        {CMD_KEY, 8'd7}, {CMD_KEY, RST_CHANGE_CHOICE},
        {CMD_KEY, 8'd5}, {CMD_KEY, RST_ENTER_CODE}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'd0;   // value[7:0]
    logic                  s_axis_tuser = 1'b0;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;          // link_byte[7:0], display_event[10:8]
    logic                  m_axis_tuser;          // kind
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    keypad_code_lock_controller_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register copies
    logic [7:0] enter_code    = RST_ENTER_CODE;
    logic [7:0] digit_limit   = RST_DIGIT_LIMIT;
    logic [1:0] wrong_limit   = RST_WRONG_LIMIT;
    logic [7:0] alarm_byte    = RST_ALARM_BYTE;
    logic [7:0] open_byte     = RST_OPEN_BYTE;
    logic [7:0] change_byte   = RST_CHANGE_BYTE;
    logic [7:0] open_choice   = RST_OPEN_CHOICE;
    logic [7:0] change_choice = RST_CHANGE_CHOICE;

    // lock state as the predictor sees it
    mode_t lock_mode      = MODE_LOAD;
    code_t ref_code       = '0;
    code_t entry_buf      = '0;
    int    entry_cnt      = 0;
    int    load_idx       = 0;
    int    wrong_cnt      = 0;
    bit    prompt_cleared = 1'b0;

    lock_item_t   keystroke_queue[$];
    lock_result_t step_results[$];
    lock_result_t expected_lock_results[$];
    lock_item_t   next_item;
    lock_result_t want;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int phase_items     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int settings_used   = 1;
    int logins          = 0;
    int alarms          = 0;
    int door_opens      = 0;
    int code_changes    = 0;

    function automatic bit is_code_digit(input logic [7:0] key);
        return key != 8'd0 && key != enter_code && key <= digit_limit;
    endfunction

    function automatic void emit_link(input logic [7:0] b);
        lock_result_t r;
        r.kind = KIND_LINK;
        r.link_byte = b;
        r.display_event = 3'd0;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void emit_event(input logic [2:0] ev);
        lock_result_t r;
        r.kind = KIND_EVENT;
        r.link_byte = 8'd0;
        r.display_event = ev;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void go_prompt();
        emit_event(EV_PROMPT);
        prompt_cleared = 1'b0;
        lock_mode = MODE_ENTRY;
    endfunction

    function automatic void store_digit(input logic [7:0] key);
        if (entry_cnt < CODE_LENGTH) begin
            entry_buf[entry_cnt] = key;
            entry_cnt++;
            emit_event(EV_STAR);
        end
    endfunction

    function automatic void clear_entry();
        entry_buf = '0;
        entry_cnt = 0;
    endfunction

    // works out the results one accepted item causes and queues them
    function automatic void lock_predict(input logic cmd, input logic [7:0] val);
        int lim;
        bit hit;
        step_results.delete();
        if (lock_mode == MODE_LOAD) begin
            if (cmd == CMD_LINK) begin
                ref_code[load_idx] = val;
                load_idx++;
                if (load_idx >= CODE_LENGTH) begin
                    load_idx = 0;
                    lock_mode = MODE_ENTRY;
                end
            end
        end else if (cmd == CMD_KEY) begin
            case (lock_mode)
                MODE_ENTRY: begin
                    if (val == enter_code) begin
                        hit = (entry_buf == ref_code);
                        lim = (wrong_limit == 2'd0) ? 1 : int'(wrong_limit);
                        emit_event(EV_CLEAR);
                        clear_entry();
                        if (hit) begin
                            emit_event(EV_MENU);
                            lock_mode = MODE_MENU;
                            logins++;
                        end else if (wrong_cnt + 1 >= lim) begin
                            wrong_cnt = 0;
                            emit_event(EV_FAILED);
                            emit_link(alarm_byte);
                            go_prompt();
                            alarms++;
                        end else begin
                            wrong_cnt++;
                            emit_event(EV_RETRY);
                            emit_event(EV_CLEAR);
                        end
                    end else if (is_code_digit(val)) begin
                        if (!prompt_cleared) begin
                            prompt_cleared = 1'b1;
                            emit_event(EV_CLEAR);
                        end
                        store_digit(val);
                    end
                end
                MODE_MENU: begin
                    // open wins when both choices share a key code
                    if (val == open_choice) begin
                        emit_link(open_byte);
                        go_prompt();
                        door_opens++;
                    end else if (val == change_choice) begin
                        emit_link(change_byte);
                        emit_event(EV_CLEAR);
                        lock_mode = MODE_NEWCODE;
                    end
                end
                default: begin
                    if (val == enter_code) begin
                        emit_link(change_byte);
                        for (int i = 0; i < CODE_LENGTH; i++)
                            emit_link(entry_buf[i]);
                        clear_entry();
                        go_prompt();
                        ref_code = '0;
                        load_idx = 0;
                        lock_mode = MODE_LOAD;
                        code_changes++;
                    end else if (is_code_digit(val)) begin
                        store_digit(val);
                    end
                end
            endcase
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_lock_results.push_back(step_results[i]);
    endfunction

    function automatic void flag_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= MAX_SHOWN_ERRORS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    endfunction

    // stimulus side

    function automatic void push_item(input logic cmd, input logic [7:0] val);
        lock_item_t it;
        it.cmd = cmd;
        it.value = val;
        keystroke_queue.push_back(it);
        phase_items++;
    endfunction

    // stray item with random content, not counted as stimulus
    function automatic void push_noise();
        lock_item_t it;
        it.cmd = 1'($urandom);
        it.value = 8'($urandom);
        keystroke_queue.push_back(it);
    endfunction

    function automatic logic [7:0] pick_digit();
        logic [7:0] k;
        do
            k = 8'($urandom_range(1, digit_limit));
        while (k == enter_code);
        return k;
    endfunction

    // true when the reference can be typed: digits first, zeros after
    function automatic bit code_enterable();
        bit tail;
        tail = 1'b0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (ref_code[i] == 8'd0)
                tail = 1'b1;
            else if (tail || !is_code_digit(ref_code[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // plans the next well-formed sequence from the lock's current mode
    task automatic plan_session();
        int n;
        case (lock_mode)
            MODE_LOAD: begin
                n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, CODE_LENGTH) : -1;
                for (int i = load_idx; i < CODE_LENGTH; i++) begin
                    if ($urandom_range(0, 99) < 8)
                        push_noise();
                    if (n < 0)
                        push_item(CMD_LINK, 8'($urandom));
                    else
                        push_item(CMD_LINK, (i < n) ? pick_digit() : 8'd0);
                end
            end
            MODE_ENTRY: begin
                if (code_enterable() && $urandom_range(0, 99) < 55) begin
                    for (int i = 0; i < CODE_LENGTH && ref_code[i] != 8'd0; i++)
                        push_item(CMD_KEY, ref_code[i]);
                end else begin
                    // up to two digits past a full buffer
                    n = $urandom_range(0, CODE_LENGTH + 2);
                    repeat (n) begin
                        if ($urandom_range(0, 99) < 10)
                            push_noise();
                        else
                            push_item(CMD_KEY, pick_digit());
                    end
                end
                push_item(CMD_KEY, enter_code);
            end
            MODE_MENU: begin
                if ($urandom_range(0, 99) < 15)
                    push_noise();
                push_item(CMD_KEY, ($urandom_range(0, 99) < 50) ? open_choice : change_choice);
            end
            default: begin
                n = $urandom_range(0, CODE_LENGTH + 1);
                repeat (n) push_item(CMD_KEY, pick_digit());
                push_item(CMD_KEY, enter_code);
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_ENTER_CODE:    enter_code = data;
            CFG_DIGIT_LIMIT:   digit_limit = data;
            CFG_WRONG_LIMIT:   wrong_limit = data[1:0];
            CFG_ALARM_BYTE:    alarm_byte = data;
            CFG_OPEN_BYTE:     open_byte = data;
            CFG_CHANGE_BYTE:   change_byte = data;
            CFG_OPEN_CHOICE:   open_choice = data;
            default:           change_choice = data;
        endcase
    endtask

    task automatic configure_phase(input int p);
        logic [7:0] v [8];
        case (p)
            2: v = '{8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            3: v = '{8'd255, 8'd255, 8'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254};
            5: v = '{RST_ENTER_CODE, RST_DIGIT_LIMIT, {6'd0, RST_WRONG_LIMIT},
                     RST_ALARM_BYTE, RST_OPEN_BYTE, RST_CHANGE_BYTE,
                     RST_OPEN_CHOICE, RST_CHANGE_CHOICE};
            default: begin
                foreach (v[i])
                    v[i] = 8'($urandom);
                v[CFG_DIGIT_LIMIT] = 8'($urandom_range(2, 255));
                // a zero limit behaves as one
                v[CFG_WRONG_LIMIT] = (p == 4) ? 8'd0 : 8'($urandom_range(1, 3));
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(CFG_ADDR_W'(i), v[i]);
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_input_idle();
        do
            @(negedge aclk);
        while (keystroke_queue.size() != 0 || s_axis_tvalid);
    endtask

    task automatic wait_drain();
        do
            @(negedge aclk);
        while (keystroke_queue.size() != 0 || s_axis_tvalid ||
               expected_lock_results.size() != 0);
        // an item with no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lock_predict(s_axis_tuser, s_axis_tdata);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (keystroke_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = keystroke_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_item.value;
                    s_axis_tuser <= next_item.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_lock_results.size() == 0) begin
                    flag_mismatch("unexpected result, tdata", 0, m_axis_tdata);
                end else begin
                    want = expected_lock_results.pop_front();
                    results_checked++;
                    if (m_axis_tuser !== want.kind)
                        flag_mismatch("kind", want.kind, m_axis_tuser);
                    if (m_axis_tdata[7:0] !== want.link_byte)
                        flag_mismatch("link_byte", want.link_byte, m_axis_tdata[7:0]);
                    if (m_axis_tdata[10:8] !== want.display_event)
                        flag_mismatch("display_event", want.display_event, m_axis_tdata[10:8]);
                    if (m_axis_tlast !== want.last)
                        flag_mismatch("last", want.last, m_axis_tlast);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            if (p == 0) begin
                foreach (DIRECTED[i])
                    push_item(DIRECTED[i][8], DIRECTED[i][7:0]);
            end else begin
                configure_phase(p);
            end
            while (phase_items < ITEMS_PER_PHASE) begin
                wait_input_idle();
                plan_session();
            end
            wait_drain();
        end
        $display("Sent %0d items under %0d register settings, checked %0d results",
                 items_accepted, settings_used, results_checked);
        $display("Logins %0d, door openings %0d, code changes %0d, alarms %0d",
                 logins, door_opens, code_changes, alarms);
        if (mismatches == 0 && expected_lock_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatches, expected_lock_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_lock_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
